/* hdl/volume_mean_downsample_2x_macros.svh */
// Assertion macros used by the downsampler RTL.
`ifndef VOLUME_MEAN_DOWNSAMPLE_2X_MACROS_SVH
`define VOLUME_MEAN_DOWNSAMPLE_2X_MACROS_SVH

`ifndef SYNTH
// Implication checked on every rising edge, off during reset.
`define VMDS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition that must never be true on a rising edge, off during reset.
`define VMDS_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define VMDS_ASSERT(label, prop, msg)
`define VMDS_NEVER(label, cond, msg)
`endif

`endif

/* hdl/vmds_pkg.sv */
// Shared types, constants and helpers of the 2x2x2 mean downsampler.
package vmds_pkg;

   // Largest output dimensions; the width by height plane is kept in the accumulator store.
   localparam int MAX_OUT_WIDTH  = 256;
   localparam int MAX_OUT_HEIGHT = 256;
   localparam int MAX_OUT_DEPTH  = 256;

   localparam int CFG_W    = 9;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + 3;

   localparam int X_W    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int Y_W    = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
   localparam int Z_W    = (MAX_OUT_DEPTH > 1) ? $clog2(MAX_OUT_DEPTH) : 1;
   localparam int DEPTH  = MAX_OUT_WIDTH * MAX_OUT_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_OUT_WIDTH  = 2'd0,
      REG_OUT_HEIGHT = 2'd1,
      REG_OUT_DEPTH  = 2'd2
   } reg_index_type;

   // What the raster counters say about the sample being transferred in.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              first;
      logic              last;
      logic              row_end;
      logic              vol_end;
   } item_info_type;

   // Last coordinate index for a dimension register: zero acts as one and
   // values above the limit act as the limit.
   function automatic logic [CFG_W:0] last_index(input logic [CFG_W-1:0] v, input int maxv);
      logic [CFG_W:0] res;
      if (v == '0) begin
         res = '0;
      end else if (int'(v) > maxv) begin
         res = (CFG_W+1)'(maxv - 1);
      end else begin
         res = {1'b0, v} - (CFG_W+1)'(1);
      end
      return res;
   endfunction

endpackage

/* hdl/volume_mean_downsample_2x.sv */
// Top level of the 2x2x2 box-filter mean downsampler.
//
// Samples of a (2*out_width) x (2*out_height) x (2*out_depth) volume are taken
// in raster order, x fastest, one per cycle, and every completed block of eight
// samples gives one result: their sum shifted right by three. Partial sums of
// the output plane under way sit in a 65536 x 19 accumulator RAM with a registered
// read; a sample reads its cell when transferred in and the sum is written back
// as the stage moves on, with the last write forwarded so that a sample may
// follow in every cycle. Sustained rate is one sample per cycle, and the input
// stalls only while a finished result waits at a stalled output. A block's last
// sample passes the stage register, then the result register. Dimension
// registers of zero act as one and values above 256 act as 256. Any write to a
// known register restarts the volume and must be made while the block is idle.
// The RAM needs no clearing pass, so samples are taken right after reset.
module volume_mean_downsample_2x
   import vmds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_mean_value,
   output logic                rsp_row_end,
   output logic                rsp_volume_end
);

   logic              accept;
   item_info_type     info;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  wr_data;
   logic [SUM_W-1:0]  rd_data;

   // An input transfer happens when valid meets no stall.
   assign accept = req_valid && !req_stall;

   vmds_raster u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .info      (info)
   );

   vmds_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (info.addr),
      .rd_data (rd_data)
   );

   vmds_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .info           (info),
      .sample         (req_sample),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value),
      .rsp_row_end    (rsp_row_end),
      .rsp_volume_end (rsp_volume_end)
   );

endmodule

/* hdl/vmds_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module vmds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the entry being written
   // returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/vmds_raster.sv */
// Configuration registers and raster position counters of the downsampler.
module vmds_raster
   import vmds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             advance,
   output item_info_type    info
);

   logic [X_W-1:0] last_x_ff, last_x_in;
   logic [Y_W-1:0] last_y_ff, last_y_in;
   logic [Z_W-1:0] last_z_ff, last_z_in;
   logic [X_W-1:0] in_x_ff, in_x_in;
   logic [Y_W-1:0] in_y_ff, in_y_in;
   logic [Z_W-1:0] in_z_ff, in_z_in;
   logic           ph_x_ff, ph_x_in;
   logic           ph_y_ff, ph_y_in;
   logic           ph_z_ff, ph_z_in;
   logic           known_reg;
   logic [CFG_W:0] clamped_w;
   logic [CFG_W:0] clamped_h;
   logic [CFG_W:0] clamped_d;

   assign clamped_w = last_index(csr_wdata, MAX_OUT_WIDTH);
   assign clamped_h = last_index(csr_wdata, MAX_OUT_HEIGHT);
   assign clamped_d = last_index(csr_wdata, MAX_OUT_DEPTH);

   // Register decode; the dimensions are held as their last index.
   always_comb begin
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      last_z_in = last_z_ff;
      known_reg = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_OUT_WIDTH: begin
               last_x_in = clamped_w[X_W-1:0];
               known_reg = 1'b1;
            end
            REG_OUT_HEIGHT: begin
               last_y_in = clamped_h[Y_W-1:0];
               known_reg = 1'b1;
            end
            REG_OUT_DEPTH: begin
               last_z_in = clamped_d[Z_W-1:0];
               known_reg = 1'b1;
            end
            default: begin
               known_reg = 1'b0;
            end
         endcase
      end
   end

   // Raster advance: x phase fastest, then block x, y phase, block y,
   // z phase and block z. A write to a known register starts a new volume.
   always_comb begin
      in_x_in = in_x_ff;
      in_y_in = in_y_ff;
      in_z_in = in_z_ff;
      ph_x_in = ph_x_ff;
      ph_y_in = ph_y_ff;
      ph_z_in = ph_z_ff;
      if (known_reg) begin
         in_x_in = '0;
         in_y_in = '0;
         in_z_in = '0;
         ph_x_in = 1'b0;
         ph_y_in = 1'b0;
         ph_z_in = 1'b0;
      end else if (advance) begin
         ph_x_in = ~ph_x_ff;
         if (ph_x_ff) begin
            if (in_x_ff == last_x_ff) begin
               in_x_in = '0;
               ph_y_in = ~ph_y_ff;
               if (ph_y_ff) begin
                  if (in_y_ff == last_y_ff) begin
                     in_y_in = '0;
                     ph_z_in = ~ph_z_ff;
                     if (ph_z_ff) begin
                        in_z_in = (in_z_ff == last_z_ff) ? '0 : in_z_ff + Z_W'(1);
                     end
                  end else begin
                     in_y_in = in_y_ff + Y_W'(1);
                  end
               end
            end else begin
               in_x_in = in_x_ff + X_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= X_W'(MAX_OUT_WIDTH - 1);
         last_y_ff <= Y_W'(MAX_OUT_HEIGHT - 1);
         last_z_ff <= Z_W'(MAX_OUT_DEPTH - 1);
         in_x_ff   <= '0;
         in_y_ff   <= '0;
         in_z_ff   <= '0;
         ph_x_ff   <= 1'b0;
         ph_y_ff   <= 1'b0;
         ph_z_ff   <= 1'b0;
      end else begin
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         last_z_ff <= last_z_in;
         in_x_ff   <= in_x_in;
         in_y_ff   <= in_y_in;
         in_z_ff   <= in_z_in;
         ph_x_ff   <= ph_x_in;
         ph_y_ff   <= ph_y_in;
         ph_z_ff   <= ph_z_in;
      end
   end

   // Cell address and block position of the current sample.
   always_comb begin
      info.addr    = ADDR_W'(int'(in_y_ff) * MAX_OUT_WIDTH + int'(in_x_ff));
      info.first   = !ph_x_ff && !ph_y_ff && !ph_z_ff;
      info.last    = ph_x_ff && ph_y_ff && ph_z_ff;
      info.row_end = (in_x_ff == last_x_ff);
      info.vol_end = (in_x_ff == last_x_ff) && (in_y_ff == last_y_ff)
                     && (in_z_ff == last_z_ff);
   end

endmodule

/* hdl/vmds_accum.sv */
// Read-modify-write stage of the accumulator store and the result register.
`include "volume_mean_downsample_2x_macros.svh"
module vmds_accum
   import vmds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  item_info_type       info,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SUM_W-1:0]    rd_data,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [SUM_W-1:0]    wr_data,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_mean_value,
   output logic                rsp_row_end,
   output logic                rsp_volume_end
);

   logic                s1_valid_ff, s1_valid_in;
   item_info_type       s1_info_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                lw_valid_ff;
   logic [ADDR_W-1:0]   lw_addr_ff;
   logic [SUM_W-1:0]    lw_data_ff;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_mean_ff;
   logic                out_row_end_ff;
   logic                out_vol_end_ff;
   logic                s1_adv;
   logic                load_out;
   logic [SUM_W-1:0]    base;
   logic [SUM_W-1:0]    sum;

   // The stage moves on unless its result would overwrite a result that is
   // still waiting for a transfer.
   assign s1_adv    = s1_valid_ff && (!s1_info_ff.last || !out_valid_ff || !rsp_stall);
   assign load_out  = s1_adv && s1_info_ff.last;
   assign req_stall = s1_valid_ff && !s1_adv;

   // Forward the latest write when it hit this cell at the edge of our read.
   assign base = (lw_valid_ff && (lw_addr_ff == s1_info_ff.addr)) ? lw_data_ff : rd_data;
   assign sum  = s1_info_ff.first ? SUM_W'(s1_sample_ff)
                                  : base + SUM_W'(s1_sample_ff);

   assign wr_en   = s1_adv;
   assign wr_addr = s1_info_ff.addr;
   assign wr_data = sum;

   // Stage and result valid bits.
   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      out_valid_in = load_out || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff   <= info;
         s1_sample_ff <= sample;
      end
      if (s1_adv) begin
         lw_addr_ff <= s1_info_ff.addr;
         lw_data_ff <= sum;
      end
      if (load_out) begin
         out_mean_ff    <= sum[SUM_W-1:3];
         out_row_end_ff <= s1_info_ff.row_end;
         out_vol_end_ff <= s1_info_ff.vol_end;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_mean_value = out_mean_ff;
   assign rsp_row_end    = out_row_end_ff;
   assign rsp_volume_end = out_vol_end_ff;

   // A waiting result is never overwritten.
   `VMDS_NEVER(a_no_overwrite, load_out && out_valid_ff && rsp_stall, "result overwritten")
   // A held stage keeps its cell until it completes.
   `VMDS_ASSERT(a_stage_hold, s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_info_ff.addr), "stage item lost")
   // The end of the volume is also the end of a row.
   `VMDS_ASSERT(a_vol_row, out_valid_ff && out_vol_end_ff |-> out_row_end_ff, "volume end without row end")

endmodule

/* tb/vmds_mean_checker.sv */
// Checker that mirrors the downsampler's registers, predicts its results and compares them.
`timescale 1ns / 1ps

module vmds_mean_checker
   import vmds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [SAMPLE_W-1:0] rsp_mean_value,
   input  logic                rsp_row_end,
   input  logic                rsp_volume_end,
   output int                  pending_count,
   output int                  mismatch_count
);

   // One output voxel as the block should give it.
   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_value;
      logic                row_end;
      logic                volume_end;
   } mean_voxel_type;

   mean_voxel_type   expected_voxels[$];
   logic [SUM_W-1:0] plane_sums[DEPTH];
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [CFG_W-1:0] depth_reg;
   int               blk_x;
   int               blk_y;
   int               blk_z;
   logic             ph_x;
   logic             ph_y;
   logic             ph_z;

   // A dimension of zero acts as one; values above the limit act as the limit.
   function automatic int effective_dim(input logic [CFG_W-1:0] value, input int limit);
      if (value == '0) return 1;
      if (int'(value) > limit) return limit;
      return int'(value);
   endfunction

   // A new volume starts with the next sample.
   task automatic restart_raster();
      blk_x = 0;
      blk_y = 0;
      blk_z = 0;
      ph_x  = 1'b0;
      ph_y  = 1'b0;
      ph_z  = 1'b0;
   endtask

   // Adds one sample to its block and queues the mean when the block is complete.
   task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value);
      int               w;
      int               h;
      int               d;
      int               cell_idx;
      logic [SUM_W-1:0] sum;
      mean_voxel_type   voxel;
      w = effective_dim(width_reg, MAX_OUT_WIDTH);
      h = effective_dim(height_reg, MAX_OUT_HEIGHT);
      d = effective_dim(depth_reg, MAX_OUT_DEPTH);
      if (blk_x >= w) blk_x = 0;
      if (blk_y >= h) blk_y = 0;
      if (blk_z >= d) blk_z = 0;
      cell_idx = blk_y * MAX_OUT_WIDTH + blk_x;

      // The first sample of a block starts its sum; the others add to it.
      if (!ph_x && !ph_y && !ph_z) begin
         sum = SUM_W'(value);
      end else begin
         sum = plane_sums[cell_idx] + SUM_W'(value);
      end
      plane_sums[cell_idx] = sum;

      if (ph_x && ph_y && ph_z) begin
         voxel.mean_value = sum[SUM_W-1:3];
         voxel.row_end    = (blk_x == w - 1);
         voxel.volume_end = voxel.row_end && (blk_y == h - 1) && (blk_z == d - 1);
         expected_voxels.push_back(voxel);
      end

      // Step the raster: x phase, x, y phase, y, z phase, z.
      ph_x = ~ph_x;
      if (!ph_x) begin
         blk_x++;
         if (blk_x >= w) begin
            blk_x = 0;
            ph_y  = ~ph_y;
            if (!ph_y) begin
               blk_y++;
               if (blk_y >= h) begin
                  blk_y = 0;
                  ph_z  = ~ph_z;
                  if (!ph_z) begin
                     blk_z++;
                     if (blk_z >= d) blk_z = 0;
                  end
               end
            end
         end
      end
   endtask

   // Compares one result transfer with the oldest expected voxel.
   task automatic check_voxel();
      mean_voxel_type want;
      if (expected_voxels.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual %h %b %b",
                  $time, rsp_mean_value, rsp_row_end, rsp_volume_end);
         mismatch_count++;
         return;
      end
      want = expected_voxels.pop_front();
      if (rsp_mean_value !== want.mean_value) begin
         $display("%0t: mean_value expected %h, actual %h", $time, want.mean_value,
                  rsp_mean_value);
         mismatch_count++;
      end
      if (rsp_row_end !== want.row_end) begin
         $display("%0t: row_end expected %b, actual %b", $time, want.row_end, rsp_row_end);
         mismatch_count++;
      end
      if (rsp_volume_end !== want.volume_end) begin
         $display("%0t: volume_end expected %b, actual %b", $time, want.volume_end,
                  rsp_volume_end);
         mismatch_count++;
      end
   endtask

   // Everything is sampled on the rising edge, where transfers happen.
   always @(posedge clock) begin
      if (reset) begin
         width_reg  = CFG_W'(MAX_OUT_WIDTH);
         height_reg = CFG_W'(MAX_OUT_HEIGHT);
         depth_reg  = CFG_W'(MAX_OUT_DEPTH);
         restart_raster();
         expected_voxels.delete();
      end else begin
         // A write to a known register also restarts the volume.
         if (csr_wr_en) begin
            case (csr_index)
               REG_OUT_WIDTH: begin
                  width_reg = csr_wdata;
                  restart_raster();
               end
               REG_OUT_HEIGHT: begin
                  height_reg = csr_wdata;
                  restart_raster();
               end
               REG_OUT_DEPTH: begin
                  depth_reg = csr_wdata;
                  restart_raster();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) accumulate_sample(req_sample);
         if (rsp_valid && !rsp_stall) check_voxel();
      end
      pending_count = expected_voxels.size();
   end

endmodule

/* tb/tb_volume_mean_downsample_2x.sv */
// Testbench top: stimulus, flow control and verdict for the 2x2x2 mean downsampler.
`timescale 1ns / 1ps

module tb_volume_mean_downsample_2x
   import vmds_pkg::*;
();

   localparam logic [1:0] REG_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         STUCK_LIMIT   = 3000;
   localparam int         PHASE_ITEMS   = 340;
   localparam int         CLAMP_ITEMS   = 64;

   // Block of samples whose mean truncates.
   localparam logic [SAMPLE_W-1:0] MIXED_BLOCK[8] = '{
      16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF
   };

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [1:0]          csr_index;
   logic [CFG_W-1:0]    csr_wdata;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SAMPLE_W-1:0] rsp_mean_value;
   logic                rsp_row_end;
   logic                rsp_volume_end;
   int                  pending_count;
   int                  mismatch_count;
   int                  send_idle_pct = 19;
   int                  recv_idle_pct = 79;
   bit                  hold_request  = 1'b0;
   int                  stuck_cycles  = 0;

   volume_mean_downsample_2x u_top (.*);

   vmds_mean_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, and one long hold-off when asked for.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en || reset)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Mostly full-range values, with the extremes and near-full values mixed in.
   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(16'hFFFF, 16'hF000));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offers one sample after a random gap and waits for its transfer.
   // Called and returning at a falling edge.
   task automatic offer_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) offer_sample(random_sample());
   endtask

   // Stops offering and waits until the block has drained.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_dims(input int w, input int h, input int d);
      quiesce();
      write_reg(REG_OUT_WIDTH, CFG_W'(w));
      write_reg(REG_OUT_HEIGHT, CFG_W'(h));
      write_reg(REG_OUT_DEPTH, CFG_W'(d));
   endtask

   // Small random volumes, mostly complete, some cut short by the next setting.
   task automatic random_phase(input int items);
      int sent;
      int w;
      int h;
      int d;
      int volume;
      int count;
      sent = 0;
      while (sent < items) begin
         w = $urandom_range(6);
         h = $urandom_range(4);
         d = $urandom_range(3);
         program_dims(w, h, d);
         volume = 8 * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * ((d == 0) ? 1 : d);
         if ($urandom_range(4) == 0)
            count = $urandom_range(volume - 1, 1);
         else
            count = volume * $urandom_range(2, 1);
         send_random(count);
         sent += count;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Dimensions from reset: a couple of samples that finish no block.
      send_random(2);

      // All dimensions zero act as one: every eight samples are a volume.
      program_dims(0, 0, 0);
      repeat (8) offer_sample('1);
      foreach (MIXED_BLOCK[i]) offer_sample(MIXED_BLOCK[i]);

      // A register write in the middle of a block starts a fresh volume.
      send_random(3);
      quiesce();
      write_reg(REG_OUT_WIDTH, CFG_W'(1));

      // A write to an unknown index leaves the block position alone.
      send_random(4);
      quiesce();
      write_reg(REG_UNUSED, '1);
      send_random(4);

      // Sender mostly busy, receiver mostly stalled; then the start of a
      // volume with the widest row.
      random_phase(PHASE_ITEMS);
      program_dims(511, 1, 1);
      send_random(CLAMP_ITEMS);

      // Sender mostly idle, receiver mostly ready; then the start of a
      // volume with the tallest plane.
      send_idle_pct = 79;
      recv_idle_pct = 19;
      random_phase(PHASE_ITEMS);
      program_dims(1, 300, 0);
      send_random(CLAMP_ITEMS);

      // No idling, with one long receiver hold-off that backs up the input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      random_phase(PHASE_ITEMS);
      program_dims(0, 1, 300);
      send_random(CLAMP_ITEMS);

      quiesce();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/vmds_pkg.sv
hdl/vmds_ram.sv
hdl/vmds_raster.sv
hdl/vmds_accum.sv
hdl/volume_mean_downsample_2x.sv
tb/vmds_mean_checker.sv
tb/tb_volume_mean_downsample_2x.sv
